>>> rtl/sha256_pkg.sv
`timescale 1ns / 1ps
package sha256_pkg;

  localparam int QueueDepth = 4;

  typedef enum logic {
    CMD_ABSORB = 1'b0,
    CMD_FINISH = 1'b1
  } cmd_t;

  // One queued transaction from the front part to the back part.
  typedef struct packed {
    logic       finish;
    logic [7:0] data;
  } item_t;

  typedef logic [31:0] hash_t [8];

  function automatic logic [31:0] init_word(input logic [2:0] idx);
    logic [31:0] r;
    case (idx)
      3'd0: r = 32'h6a09e667;
      3'd1: r = 32'hbb67ae85;
      3'd2: r = 32'h3c6ef372;
      3'd3: r = 32'ha54ff53a;
      3'd4: r = 32'h510e527f;
      3'd5: r = 32'h9b05688c;
      3'd6: r = 32'h1f83d9ab;
      default: r = 32'h5be0cd19;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] r;
    case (t)
      6'd0: r = 32'h428a2f98; 6'd1: r = 32'h71374491; 6'd2: r = 32'hb5c0fbcf;
      6'd3: r = 32'he9b5dba5; 6'd4: r = 32'h3956c25b; 6'd5: r = 32'h59f111f1;
      6'd6: r = 32'h923f82a4; 6'd7: r = 32'hab1c5ed5; 6'd8: r = 32'hd807aa98;
      6'd9: r = 32'h12835b01; 6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
      6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe; 6'd14: r = 32'h9bdc06a7;
      6'd15: r = 32'hc19bf174; 6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
      6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc; 6'd20: r = 32'h2de92c6f;
      6'd21: r = 32'h4a7484aa; 6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
      6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d; 6'd26: r = 32'hb00327c8;
      6'd27: r = 32'hbf597fc7; 6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
      6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967; 6'd32: r = 32'h27b70a85;
      6'd33: r = 32'h2e1b2138; 6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
      6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb; 6'd38: r = 32'h81c2c92e;
      6'd39: r = 32'h92722c85; 6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
      6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3; 6'd44: r = 32'hd192e819;
      6'd45: r = 32'hd6990624; 6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
      6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08; 6'd50: r = 32'h2748774c;
      6'd51: r = 32'h34b0bcb5; 6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
      6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3; 6'd56: r = 32'h748f82ee;
      6'd57: r = 32'h78a5636f; 6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
      6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb; 6'd62: r = 32'hbef9a3f7;
      default: r = 32'hc67178f2;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/sha256_front.sv
`timescale 1ns / 1ps
module sha256_front
  import sha256_pkg::*;
#(
  parameter int Depth = QueueDepth
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       valid,
  output logic       stall,
  input  logic       command,
  input  logic [7:0] data_byte,
  output logic       q_valid,
  input  logic       q_pop,
  output item_t      q_item
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  item_t         mem [Depth];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;
  logic          push;

  assign stall   = (count == (AW+1)'(Depth));
  assign push    = valid && !stall;
  assign q_valid = (count != '0);
  assign q_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= '{finish: (command == CMD_FINISH), data: data_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == AW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (AW+1)'(push) - (AW+1)'(q_pop);
    end
  end

endmodule

>>> rtl/sha256_back.sv
`timescale 1ns / 1ps
module sha256_back
  import sha256_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  output logic        q_pop,
  input  item_t       q_item,
  output logic        valid,
  input  logic        stall,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_ROUND,
    S_FOLD,
    S_EMIT
  } state_t;

  state_t      state;
  // block buffer held as 16 big-endian words, written a byte lane at a time
  logic [31:0] buf_mem [16];
  logic [5:0]  fill_count;
  logic [63:0] message_bits;
  logic [63:0] total_bits;
  logic        finishing;
  logic        last_block;
  logic [31:0] hash_words [8];
  logic [31:0] sched [16];
  logic [31:0] wv [8];
  logic [5:0]  round_count;
  logic [2:0]  emit_idx;

  // padding write port
  logic        pad_we;
  logic [5:0]  pad_addr;
  logic [7:0]  pad_byte;

  logic [31:0] w_new, t1, t2, s0, s1, big0, big1, ch, mj, w_blk;

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  assign q_pop = (state == S_IDLE) && q_valid;

  always_comb begin
    w_blk = buf_mem[round_count[3:0]];
    s0 = ror(sched[1], 7) ^ ror(sched[1], 18) ^ (sched[1] >> 3);
    s1 = ror(sched[14], 17) ^ ror(sched[14], 19) ^ (sched[14] >> 10);
    w_new = (round_count < 6'd16) ? w_blk : (sched[0] + s0 + sched[9] + s1);
    big1 = ror(wv[4], 6) ^ ror(wv[4], 11) ^ ror(wv[4], 25);
    ch   = (wv[4] & wv[5]) ^ (~wv[4] & wv[6]);
    t1   = wv[7] + big1 + ch + round_k(round_count) + w_new;
    big0 = ror(wv[0], 2) ^ ror(wv[0], 13) ^ ror(wv[0], 22);
    mj   = (wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]);
    t2   = big0 + mj;
  end

  always_comb begin
    pad_byte = 8'h00;
    if (pad_addr >= 6'd56 && last_block) begin
      pad_byte = total_bits[(7 - 32'(pad_addr[2:0])) * 8 +: 8];
    end
  end

  assign pad_we = (state == S_PAD);

  always_ff @(posedge clk) begin
    if (q_pop && !q_item.finish) begin
      buf_mem[fill_count[5:2]][{~fill_count[1:0], 3'b000} +: 8] <= q_item.data;
    end else if (q_pop && q_item.finish) begin
      buf_mem[fill_count[5:2]][{~fill_count[1:0], 3'b000} +: 8] <= 8'h80;
    end else if (pad_we) begin
      buf_mem[pad_addr[5:2]][{~pad_addr[1:0], 3'b000} +: 8] <= pad_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      fill_count   <= '0;
      message_bits <= '0;
      finishing    <= 1'b0;
      last_block   <= 1'b0;
      round_count  <= '0;
      emit_idx     <= '0;
      valid        <= 1'b0;
      pad_addr     <= '0;
      for (int i = 0; i < 8; i++) hash_words[i] <= init_word(3'(i));
    end else begin
      case (state)
        S_IDLE: begin
          if (q_pop) begin
            if (!q_item.finish) begin
              fill_count <= fill_count + 1'b1;
              if (fill_count == 6'd63) begin
                finishing <= 1'b0;
                state     <= S_ROUND;
                for (int i = 0; i < 8; i++) wv[i] <= hash_words[i];
              end
            end else begin
              total_bits <= message_bits + {55'd0, fill_count, 3'd0};
              finishing  <= 1'b1;
              last_block <= (fill_count < 6'd56);
              if (fill_count == 6'd63) begin
                // 0x80 filled the block; compress it, then a length-only block
                state <= S_ROUND;
                for (int i = 0; i < 8; i++) wv[i] <= hash_words[i];
              end else begin
                pad_addr <= fill_count + 1'b1;
                state    <= S_PAD;
              end
            end
          end
        end
        S_PAD: begin
          pad_addr <= pad_addr + 1'b1;
          if (pad_addr == 6'd63) begin
            state <= S_ROUND;
            for (int i = 0; i < 8; i++) wv[i] <= hash_words[i];
          end
        end
        S_ROUND: begin
          for (int i = 0; i < 15; i++) sched[i] <= sched[i+1];
          sched[15] <= w_new;
          wv[7] <= wv[6]; wv[6] <= wv[5]; wv[5] <= wv[4]; wv[4] <= wv[3] + t1;
          wv[3] <= wv[2]; wv[2] <= wv[1]; wv[1] <= wv[0]; wv[0] <= t1 + t2;
          round_count <= round_count + 1'b1;
          if (round_count == 6'd63) state <= S_FOLD;
        end
        S_FOLD: begin
          for (int i = 0; i < 8; i++) hash_words[i] <= hash_words[i] + wv[i];
          if (!finishing) begin
            message_bits <= message_bits + 64'd512;
            state        <= S_IDLE;
          end else if (!last_block) begin
            last_block <= 1'b1;
            pad_addr   <= '0;
            state      <= S_PAD;
          end else begin
            emit_idx    <= '0;
            valid       <= 1'b1;
            digest_word <= hash_words[0] + wv[0];
            word_index  <= '0;
            last_word   <= 1'b0;
            state       <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!stall) begin
            if (emit_idx == 3'd7) begin
              valid        <= 1'b0;
              fill_count   <= '0;
              message_bits <= '0;
              finishing    <= 1'b0;
              for (int i = 0; i < 8; i++) hash_words[i] <= init_word(3'(i));
              state <= S_IDLE;
            end else begin
              emit_idx    <= emit_idx + 1'b1;
              digest_word <= hash_words[emit_idx + 1'b1];
              word_index  <= emit_idx + 1'b1;
              last_word   <= (emit_idx == 3'd6);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/sha256_byte_stream_hash_unit.sv
`timescale 1ns / 1ps
// Absorb: one byte per cycle off the queue while the back part idles; the 64th byte starts
// the compression (64 rounds, then a fold). Finish: padding from the 0x80 to the end of the
// block, then compression; if the length does not fit, a second padding pass over a whole
// block and one more compression. Then 8 digest words, one per cycle unless stalled. The
// single round unit sets the pace. A 4-entry queue takes input while the compression runs.
// Synchronous reset loads the initial hash values and clears counts and queue.
module sha256_byte_stream_hash_unit
  import sha256_pkg::*;
#(
  parameter int QDepth = QueueDepth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  logic  q_valid;
  logic  q_pop;
  item_t q_item;

  sha256_front #(.Depth(QDepth)) u_front (
    .clk, .rst,
    .valid(in_valid), .stall(in_stall),
    .command, .data_byte,
    .q_valid, .q_pop, .q_item
  );

  sha256_back u_back (
    .clk, .rst,
    .q_valid, .q_pop, .q_item,
    .valid(out_valid), .stall(out_stall),
    .digest_word, .word_index, .last_word
  );

endmodule
